FILE: sv/ktq_pkg.sv
package ktq_pkg;

   // most dispatches one tick may produce
   localparam int unsigned MAX_OUT = 16;
   localparam logic [15:0] LEAD_RESET = 16'd3000;

   typedef enum logic [3:0] {
      ACT_TICK           = 4'd0,
      ACT_ADD            = 4'd1,
      ACT_ADD_ABSENT     = 4'd2,
      ACT_ADD_UNIQUE     = 4'd3,
      ACT_ADD_UNIQUE_TAG = 4'd4,
      ACT_CLEAR          = 4'd5,
      ACT_REMOVE         = 4'd6,
      ACT_REMOVE_TAG     = 4'd7,
      ACT_CONTINUE       = 4'd8
   } action_type;

   typedef enum logic [2:0] {
      KIND_ADDED      = 3'd0,
      KIND_NOT_ADDED  = 3'd1,
      KIND_DONE       = 3'd2,
      KIND_DISPATCH   = 3'd3,
      KIND_NOTHING    = 3'd4
   } kind_type;

   typedef struct packed {
      logic [31:0] due;
      logic [31:0] contact;
      logic [31:0] tag;
   } entry_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_TAKE,
      OP_DROP_START,
      OP_DROP_STEP,
      OP_DROP_END,
      OP_SCAN,
      OP_INS_START,
      OP_INS_SHIFT,
      OP_INS_NEW,
      OP_CLEAR,
      OP_LEAD,
      OP_ADJUST,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctrl_type;

   typedef struct packed {
      logic [3:0] act;
      logic       more;
      logic       tick_more;
      logic       due_ok;
      logic       pend_vld;
      logic       rsp_free;
      logic       reject;
      logic       later;
      logic       at_bottom;
      logic       dt_pos;
      logic       empty;
   } status_type;

   // signed value of d is greater than zero
   function automatic logic is_later(input logic [31:0] d);
      return (d != 32'd0) && !d[31];
   endfunction

endpackage

FILE: sv/ktq_if.sv
interface ktq_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [30:0] wait_time;
   logic [31:0] contact;
   logic [31:0] tag;
   modport source (output valid, action, wait_time, contact, tag, input ready);
   modport sink (input valid, action, wait_time, contact, tag, output ready);
endinterface

interface ktq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] out_contact;
   logic [31:0] out_tag;
   logic        last;
   modport source (output valid, kind, out_contact, out_tag, last, input ready);
   modport sink (input valid, kind, out_contact, out_tag, last, output ready);
endinterface

FILE: sv/ktq_ram.sv
module ktq_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: sv/ktq_ctrl.sv
module ktq_ctrl import ktq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output ctrl_type   ctrl
);
   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_TICK_RD, S_TICK_EX, S_DROP_RD, S_DROP_EX,
      S_SCAN_RD, S_SCAN_EX, S_INS_RD, S_INS_EX, S_INS_NEW,
      S_CONT_EX, S_CONT_CHK, S_ADJ_RD, S_ADJ_EX, S_DONE
   } state_type;

   state_type state_ff, state_in;
   dp_op_type op;

   assign req_ready = (state_ff == S_IDLE);
   assign ctrl.op   = op;

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_ACCEPT;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.act)
               ACT_TICK: state_in = S_TICK_RD;
               ACT_ADD, ACT_ADD_ABSENT: state_in = S_SCAN_RD;
               ACT_ADD_UNIQUE, ACT_ADD_UNIQUE_TAG,
               ACT_REMOVE, ACT_REMOVE_TAG: state_in = S_DROP_RD;
               ACT_CLEAR: begin
                  op       = OP_CLEAR;
                  state_in = S_DONE;
               end
               ACT_CONTINUE: state_in = status.empty ? S_DONE : S_CONT_EX;
               default: state_in = S_DONE;
            endcase
         end
         S_TICK_RD: begin
            if (status.tick_more) begin
               state_in = S_TICK_EX;
            end else begin
               op       = OP_DROP_START;
               state_in = S_DROP_RD;
            end
         end
         S_TICK_EX: begin
            priority if (!status.due_ok) begin
               op       = OP_DROP_START;
               state_in = S_DROP_RD;
            end else if (status.pend_vld && !status.rsp_free) begin
               state_in = S_TICK_EX;
            end else begin
               op       = OP_TAKE;
               state_in = S_TICK_RD;
            end
         end
         S_DROP_RD: begin
            if (status.more) begin
               state_in = S_DROP_EX;
            end else begin
               op = OP_DROP_END;
               state_in = (status.act == ACT_ADD_UNIQUE || status.act == ACT_ADD_UNIQUE_TAG)
                          ? S_SCAN_RD : S_DONE;
            end
         end
         S_DROP_EX: begin
            op       = OP_DROP_STEP;
            state_in = S_DROP_RD;
         end
         S_SCAN_RD: begin
            priority if (status.more) begin
               state_in = S_SCAN_EX;
            end else if (status.reject) begin
               state_in = S_DONE;
            end else begin
               op       = OP_INS_START;
               state_in = S_INS_RD;
            end
         end
         S_SCAN_EX: begin
            op       = OP_SCAN;
            state_in = S_SCAN_RD;
         end
         S_INS_RD: state_in = status.at_bottom ? S_INS_NEW : S_INS_EX;
         S_INS_EX: begin
            if (status.later) begin
               op       = OP_INS_SHIFT;
               state_in = S_INS_RD;
            end else begin
               state_in = S_INS_NEW;
            end
         end
         S_INS_NEW: begin
            op       = OP_INS_NEW;
            state_in = S_DONE;
         end
         S_CONT_EX: begin
            op       = OP_LEAD;
            state_in = S_CONT_CHK;
         end
         S_CONT_CHK: state_in = status.dt_pos ? S_ADJ_RD : S_DONE;
         S_ADJ_RD: state_in = status.more ? S_ADJ_EX : S_DONE;
         S_ADJ_EX: begin
            op       = OP_ADJUST;
            state_in = S_ADJ_RD;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               op       = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

FILE: sv/ktq_dp.sv
module ktq_dp import ktq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   output status_type  status,
   input  logic [3:0]  req_action,
   input  logic [30:0] req_wait_time,
   input  logic [31:0] req_contact,
   input  logic [31:0] req_tag,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_out_contact,
   output logic [31:0] rsp_out_tag,
   output logic        rsp_last
);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [31:0]   now_ff;
   logic [CW-1:0] count_ff, rp_ff, wp_ff, n_ff;
   logic [15:0]   lead_ff;
   logic [3:0]    act_ff;
   logic [31:0]   due_new_ff, con_ff, tag_ff, dt_ff;
   logic          hit_ff, dup_ff, ok_ff;
   logic          pend_vld_ff;
   logic [31:0]   pend_con_ff, pend_tag_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   logic [2:0]    rsp_kind_ff;
   logic [31:0]   rsp_con_ff, rsp_tag_ff;

   logic          ram_we;
   entry_type     ram_wdata, rd;
   logic [95:0]   ram_rdata;
   logic          match, con_eq, rsp_free;

   ktq_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff[AW-1:0]),
      .wdata (ram_wdata),
      .raddr (rp_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign rd       = entry_type'(ram_rdata);
   assign con_eq   = (rd.contact == con_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // removal match: contact, plus tag for the tag variants; never on a tick
   always_comb begin
      unique case (act_ff)
         ACT_ADD_UNIQUE, ACT_REMOVE: match = con_eq;
         ACT_ADD_UNIQUE_TAG, ACT_REMOVE_TAG: match = con_eq && (rd.tag == tag_ff);
         default: match = 1'b0;
      endcase
   end

   // store write port
   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = rd;
      unique case (ctrl.op)
         OP_DROP_STEP: ram_we = !match;
         OP_INS_SHIFT: ram_we = 1'b1;
         OP_INS_NEW: begin
            ram_we    = 1'b1;
            ram_wdata = '{due: due_new_ff, contact: con_ff, tag: tag_ff};
         end
         OP_ADJUST: begin
            ram_we        = 1'b1;
            ram_wdata.due = rd.due - dt_ff;
         end
         default: ram_we = 1'b0;
      endcase
   end

   always_comb begin
      status.act       = act_ff;
      status.more      = (rp_ff < count_ff);
      status.tick_more = (rp_ff < count_ff) && (32'(n_ff) < MAX_OUT);
      status.due_ok    = !is_later(rd.due - now_ff);
      status.pend_vld  = pend_vld_ff;
      status.rsp_free  = rsp_free;
      status.reject    = ((act_ff == ACT_ADD_ABSENT) && hit_ff) || dup_ff
                         || (32'(count_ff) >= 32'(DEPTH));
      status.later     = is_later(rd.due - due_new_ff);
      status.at_bottom = (wp_ff == '0);
      status.dt_pos    = is_later(dt_ff);
      status.empty     = (count_ff == '0);
   end

   // request, pointers and queue bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff      <= '0;
         count_ff    <= '0;
         lead_ff     <= LEAD_RESET;
         pend_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            lead_ff <= csr_wr_data;
         end
         unique case (ctrl.op)
            OP_ACCEPT: begin
               if (req_action == ACT_TICK) begin
                  now_ff <= now_ff + 32'd1;
               end
               pend_vld_ff <= 1'b0;
            end
            OP_TAKE: pend_vld_ff <= 1'b1;
            OP_DROP_END: count_ff <= wp_ff;
            OP_INS_NEW: count_ff <= count_ff + 1'b1;
            OP_CLEAR: count_ff <= '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         OP_ACCEPT: begin
            act_ff     <= req_action;
            due_new_ff <= now_ff + {1'b0, req_wait_time};
            con_ff     <= req_contact;
            tag_ff     <= req_tag;
            rp_ff      <= '0;
            wp_ff      <= '0;
            n_ff       <= '0;
            hit_ff     <= 1'b0;
            dup_ff     <= 1'b0;
            ok_ff      <= 1'b0;
         end
         OP_TAKE: begin
            pend_con_ff <= rd.contact;
            pend_tag_ff <= rd.tag;
            n_ff        <= n_ff + 1'b1;
            rp_ff       <= rp_ff + 1'b1;
         end
         OP_DROP_START: begin
            rp_ff <= n_ff;
            wp_ff <= '0;
         end
         OP_DROP_STEP: begin
            rp_ff <= rp_ff + 1'b1;
            if (!match) begin
               wp_ff <= wp_ff + 1'b1;
            end
         end
         OP_DROP_END: begin
            rp_ff  <= '0;
            hit_ff <= 1'b0;
            dup_ff <= 1'b0;
         end
         OP_SCAN: begin
            rp_ff <= rp_ff + 1'b1;
            if (con_eq) begin
               hit_ff <= 1'b1;
               if (rd.due == due_new_ff) begin
                  dup_ff <= 1'b1;
               end
            end
         end
         OP_INS_START: begin
            rp_ff <= count_ff - 1'b1;
            wp_ff <= count_ff;
         end
         OP_INS_SHIFT: begin
            rp_ff <= rp_ff - 1'b1;
            wp_ff <= wp_ff - 1'b1;
         end
         OP_INS_NEW: ok_ff <= 1'b1;
         OP_LEAD: dt_ff <= rd.due - now_ff - {16'd0, lead_ff};
         OP_ADJUST: begin
            rp_ff <= rp_ff + 1'b1;
            wp_ff <= wp_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // result register: a dispatch ahead of the next one, or the closing result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((ctrl.op == OP_TAKE && pend_vld_ff) || ctrl.op == OP_FINISH) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == OP_TAKE && pend_vld_ff) begin
         rsp_kind_ff <= KIND_DISPATCH;
         rsp_con_ff  <= pend_con_ff;
         rsp_tag_ff  <= pend_tag_ff;
         rsp_last_ff <= 1'b0;
      end else if (ctrl.op == OP_FINISH) begin
         rsp_last_ff <= 1'b1;
         if (act_ff == ACT_TICK && pend_vld_ff) begin
            rsp_kind_ff <= KIND_DISPATCH;
            rsp_con_ff  <= pend_con_ff;
            rsp_tag_ff  <= pend_tag_ff;
         end else begin
            rsp_con_ff <= '0;
            rsp_tag_ff <= '0;
            unique case (act_ff)
               ACT_TICK: rsp_kind_ff <= KIND_NOTHING;
               ACT_ADD, ACT_ADD_ABSENT, ACT_ADD_UNIQUE, ACT_ADD_UNIQUE_TAG:
                  rsp_kind_ff <= ok_ff ? KIND_ADDED : KIND_NOT_ADDED;
               default: rsp_kind_ff <= KIND_DONE;
            endcase
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_contact = rsp_con_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_last        = rsp_last_ff;
endmodule

FILE: sv/keyed_timer_queue.sv
// Sorted timer queue of up to DEPTH entries (due time, contact, tag) held in
// one registered-read RAM, ordered by signed due time with ties in arrival
// order. A request is taken only when the previous one has finished its
// store walk; its last result may still wait in the output register. An
// entry visit is an address state, then a registered-data state. Ticks and
// removes walk the whole store whatever the dispatch count; adds scan it,
// then shift entries (replacing modes walk a removal first); continue reads
// the head and may rewrite every entry; clear and unknown actions visit none.
// Result back-pressure stalls. lead_time is to be written via csr_wr_en /
// csr_wr_data only while no request is in progress (not enforced here).
module keyed_timer_queue import ktq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   ktq_req_if.sink     req_ch,
   ktq_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   ctrl_type   ctrl;
   status_type status;

   ktq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   ktq_dp #(.DEPTH(DEPTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_action      (req_ch.action),
      .req_wait_time   (req_ch.wait_time),
      .req_contact     (req_ch.contact),
      .req_tag         (req_ch.tag),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_kind        (rsp_ch.kind),
      .rsp_out_contact (rsp_ch.out_contact),
      .rsp_out_tag     (rsp_ch.out_tag),
      .rsp_last        (rsp_ch.last)
   );
endmodule

FILE: tb/tb_keyed_timer_queue.sv
`timescale 1ns / 1ps

module tb_keyed_timer_queue;
   import ktq_pkg::*;

   localparam int DEPTH      = 16;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [3:0]  action;
      logic [30:0] wait_time;
      logic [31:0] contact;
      logic [31:0] tag;
   } request_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] contact;
      logic [31:0] tag;
      logic        last;
   } answer_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [15:0] csr_wr_data;

   ktq_req_if req_ch ();
   ktq_rsp_if rsp_ch ();

   keyed_timer_queue #(.DEPTH(DEPTH)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // mirror of the timer store
   logic [31:0] now_mirror;
   logic [31:0] due_mirror[DEPTH];
   logic [31:0] contact_mirror[DEPTH];
   logic [31:0] tag_mirror[DEPTH];
   int          count_mirror;
   logic [15:0] lead_mirror;

   request_type pending_requests[$];
   answer_type  expected_answers[$];

   int  failures;
   int  idle_cycles;
   bit  quiet_phase;
   bit  drain_pause;
   int  hold_off;
   int  send_gap;
   int  take_gap;

   function automatic bit later_than_zero(logic [31:0] d);
      return d != 0 && !d[31];
   endfunction

   function automatic void drop_entries(logic [31:0] c, logic [31:0] t, bit by_tag);
      int w;
      w = 0;
      for (int r = 0; r < count_mirror; r++) begin
         if (!(contact_mirror[r] == c && (!by_tag || tag_mirror[r] == t))) begin
            due_mirror[w]     = due_mirror[r];
            contact_mirror[w] = contact_mirror[r];
            tag_mirror[w]     = tag_mirror[r];
            w++;
         end
      end
      count_mirror = w;
   endfunction

   function automatic bit place_entry(logic [30:0] wt, logic [31:0] c, logic [31:0] t);
      logic [31:0] due;
      int pos;
      due = now_mirror + {1'b0, wt};
      if (count_mirror >= DEPTH) return 0;
      for (int i = 0; i < count_mirror; i++)
         if (due_mirror[i] == due && contact_mirror[i] == c) return 0;
      pos = count_mirror;
      for (int i = count_mirror - 1; i >= 0; i--)
         if (later_than_zero(due_mirror[i] - due)) pos = i;
      for (int i = count_mirror; i > pos; i--) begin
         due_mirror[i]     = due_mirror[i-1];
         contact_mirror[i] = contact_mirror[i-1];
         tag_mirror[i]     = tag_mirror[i-1];
      end
      due_mirror[pos]     = due;
      contact_mirror[pos] = c;
      tag_mirror[pos]     = t;
      count_mirror++;
      return 1;
   endfunction

   // work out the answers to one request and queue them
   function automatic void predict_answers(request_type rq);
      bit ok;
      int n;
      logic [31:0] dt;
      n = 0;
      case (rq.action)
         ACT_TICK: begin
            now_mirror++;
            while (n < MAX_OUT && count_mirror > 0 &&
                   !later_than_zero(due_mirror[0] - now_mirror)) begin
               expected_answers.push_back({KIND_DISPATCH, contact_mirror[0], tag_mirror[0], 1'b0});
               for (int i = 1; i < count_mirror; i++) begin
                  due_mirror[i-1]     = due_mirror[i];
                  contact_mirror[i-1] = contact_mirror[i];
                  tag_mirror[i-1]     = tag_mirror[i];
               end
               count_mirror--;
               n++;
            end
            if (n == 0) expected_answers.push_back({KIND_NOTHING, 32'd0, 32'd0, 1'b1});
            else expected_answers[$].last = 1'b1;
            return;
         end
         ACT_ADD, ACT_ADD_ABSENT, ACT_ADD_UNIQUE, ACT_ADD_UNIQUE_TAG: begin
            ok = 1;
            if (rq.action == ACT_ADD_ABSENT) begin
               for (int i = 0; i < count_mirror; i++)
                  if (contact_mirror[i] == rq.contact) ok = 0;
            end else if (rq.action == ACT_ADD_UNIQUE) begin
               drop_entries(rq.contact, rq.tag, 0);
            end else if (rq.action == ACT_ADD_UNIQUE_TAG) begin
               drop_entries(rq.contact, rq.tag, 1);
            end
            if (ok) ok = place_entry(rq.wait_time, rq.contact, rq.tag);
            expected_answers.push_back({ok ? KIND_ADDED : KIND_NOT_ADDED, 32'd0, 32'd0, 1'b1});
            return;
         end
         ACT_CLEAR:      count_mirror = 0;
         ACT_REMOVE:     drop_entries(rq.contact, rq.tag, 0);
         ACT_REMOVE_TAG: drop_entries(rq.contact, rq.tag, 1);
         ACT_CONTINUE: begin
            if (count_mirror > 0) begin
               dt = due_mirror[0] - now_mirror - {16'd0, lead_mirror};
               if (later_than_zero(dt))
                  for (int i = 0; i < count_mirror; i++) due_mirror[i] -= dt;
            end
         end
         default: ;
      endcase
      expected_answers.push_back({KIND_DONE, 32'd0, 32'd0, 1'b1});
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // driver: offer queued requests, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap     <= 0;
      end else if (req_ch.valid && !req_ch.ready) begin
         // hold the offered request
      end else begin
         if (req_ch.valid) predict_answers({req_ch.action, req_ch.wait_time,
                                            req_ch.contact, req_ch.tag});
         if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_requests.size() > 0 && !drain_pause &&
                      !(req_ch.valid == 0 && !quiet_phase && $urandom_range(0, 9) == 0)) begin
            request_type rq;
            rq = pending_requests.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.action    <= rq.action;
            req_ch.wait_time <= rq.wait_time;
            req_ch.contact   <= rq.contact;
            req_ch.tag       <= rq.tag;
            if (!quiet_phase && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 19);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: accept answers, with random stalls, and compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_gap     <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
               $error("unexpected answer kind=%0d", rsp_ch.kind);
               failures++;
            end else begin
               answer_type ex;
               ex = expected_answers.pop_front();
               if (rsp_ch.kind !== ex.kind) begin
                  $error("kind: expected %0d, got %0d", ex.kind, rsp_ch.kind); failures++;
               end
               if (rsp_ch.out_contact !== ex.contact) begin
                  $error("out_contact: expected %h, got %h", ex.contact, rsp_ch.out_contact);
                  failures++;
               end
               if (rsp_ch.out_tag !== ex.tag) begin
                  $error("out_tag: expected %h, got %h", ex.tag, rsp_ch.out_tag); failures++;
               end
               if (rsp_ch.last !== ex.last) begin
                  $error("last: expected %0d, got %0d", ex.last, rsp_ch.last); failures++;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off     <= hold_off - 1;
            rsp_ch.ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap     <= take_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 9) == 0) take_gap <= $urandom_range(1, 19);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] pick_contact();
      return $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 5);
   endfunction

   function automatic request_type random_request();
      request_type rq;
      int sel;
      sel = $urandom_range(0, 99);
      rq.contact   = pick_contact();
      rq.tag       = $urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 2);
      rq.wait_time = $urandom_range(0, 5) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 12));
      if (sel < 35)      rq.action = ACT_TICK;
      else if (sel < 55) rq.action = ACT_ADD;
      else if (sel < 63) rq.action = ACT_ADD_ABSENT;
      else if (sel < 71) rq.action = ACT_ADD_UNIQUE;
      else if (sel < 79) rq.action = ACT_ADD_UNIQUE_TAG;
      else if (sel < 81) rq.action = ACT_CLEAR;
      else if (sel < 87) rq.action = ACT_REMOVE;
      else if (sel < 93) rq.action = ACT_REMOVE_TAG;
      else if (sel < 98) rq.action = ACT_CONTINUE;
      else               rq.action = 4'($urandom_range(9, 15));
      return rq;
   endfunction

   task automatic push(logic [3:0] a, logic [30:0] w, logic [31:0] c, logic [31:0] t);
      pending_requests.push_back({a, w, c, t});
   endtask

   // wait until every request is out and every answer is in
   task automatic settle();
      while (pending_requests.size() > 0 || req_ch.valid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_lead(logic [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      lead_mirror = v;
   endtask

   initial begin
      logic [15:0] leads[4];
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 16'd0;
      req_ch.valid = 1'b0;
      req_ch.action = 4'd0; req_ch.wait_time = '0; req_ch.contact = '0; req_ch.tag = '0;
      rsp_ch.ready = 1'b0;
      failures = 0; idle_cycles = 0; quiet_phase = 0; drain_pause = 0; hold_off = 0;
      send_gap = 0; take_gap = 0;
      now_mirror = 0; count_mirror = 0; lead_mirror = LEAD_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, duplicates, many due at once, continue, unknown
      push(ACT_CONTINUE, 0, 0, 0);
      push(ACT_TICK, 0, 0, 0);
      push(ACT_ADD, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      push(ACT_ADD, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'h0);
      push(ACT_ADD_ABSENT, 5, 32'hFFFFFFFF, 1);
      push(ACT_CONTINUE, 0, 0, 0);
      push(ACT_REMOVE_TAG, 0, 32'hFFFFFFFF, 32'h0);
      push(ACT_ADD_UNIQUE, 0, 32'hFFFFFFFF, 7);
      for (int i = 0; i < 17; i++) push(ACT_ADD, 1, i, 32'h55AA0000 + i);
      push(ACT_TICK, 0, 0, 0);
      push(ACT_TICK, 0, 0, 0);
      push(ACT_ADD_UNIQUE_TAG, 3, 2, 32'hAAAAAAAA);
      push(ACT_REMOVE, 0, 3, 0);
      push(ACT_CLEAR, 0, 0, 0);
      push(4'd15, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      push(4'd9, 0, 0, 0);
      settle();

      // random phases, one per lead setting including both extremes
      leads = '{16'd0, 16'hFFFF, 16'd5, LEAD_RESET};
      for (int ph = 0; ph < 4; ph++) begin
         write_lead(leads[ph]);
         if (ph == 3) quiet_phase = 1;
         for (int i = 0; i < 100; i++) pending_requests.push_back(random_request());
         if (ph == 1) begin
            // long receiver hold-off while requests keep coming
            hold_off <= 400;
            @(posedge clock);
         end
         if (ph == 2) begin
            // sender pauses half way until the block has drained
            while (pending_requests.size() > 50) @(posedge clock);
            drain_pause = 1;
            while (req_ch.valid || expected_answers.size() > 0) @(posedge clock);
            drain_pause = 0;
         end
         settle();
      end

      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

FILE: filelist.f
sv/ktq_pkg.sv
sv/ktq_if.sv
sv/ktq_ram.sv
sv/ktq_ctrl.sv
sv/ktq_dp.sv
sv/keyed_timer_queue.sv
tb/tb_keyed_timer_queue.sv
